// File: design/cc20_pkg.sv
// Shared types and constants for the ChaCha20 stream XOR block.
// Used by the quarter-round cell, the round core and the top level.
`default_nettype none

package cc20_pkg;

  localparam int WORD_W      = 32;
  localparam int DATA_W      = 64;
  localparam int STATE_WORDS = 16;
  localparam int CELLS       = 4;
  localparam int KS_WORDS    = 8;
  localparam int POS_W       = $clog2(KS_WORDS);

  localparam int DOUBLE_ROUNDS = 10;
  localparam int NUM_ROUNDS    = 2 * DOUBLE_ROUNDS;
  localparam int RND_W         = $clog2(NUM_ROUNDS);

  // configuration register indexes
  localparam int NUM_CFG   = 6;
  localparam int CFG_IDX_W = $clog2(NUM_CFG);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY01 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY23 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY45 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY67 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_IV01  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_IV23  = CFG_IDX_W'(5);

  typedef logic [STATE_WORDS-1:0][WORD_W-1:0] cc20_state_t;
  typedef logic [KS_WORDS-1:0][DATA_W-1:0]    cc20_block_t;

  localparam logic [CELLS-1:0][WORD_W-1:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  // one column of the working state, held by one cell
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } cc20_col_t;

  typedef struct packed {
    logic [7:0][WORD_W-1:0] key;
    logic [2:0][WORD_W-1:0] nonce;
  } cc20_cfg_t;

  typedef struct packed {
    logic              flush;
    logic              take;
    logic [WORD_W-1:0] ctr;
  } cc20_core_ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_in;
    logic [3:0]        byte_count;
    logic              last;
  } cc20_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic [3:0]        out_count;
    logic              out_last;
  } cc20_out_t;

endpackage

`default_nettype wire

// File: design/cc20_qr_cell.sv
// One cell of the round chain: holds a column of the working state and
// computes its quarter round. Depends on cc20_pkg.
`default_nettype none

module cc20_qr_cell (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic               step_i,
  input  cc20_pkg::cc20_col_t init_i,
  input  cc20_pkg::cc20_col_t nxt_i,
  output cc20_pkg::cc20_col_t col_o,
  output cc20_pkg::cc20_col_t qr_o
);
  import cc20_pkg::*;

  cc20_col_t col_q, col_d;
  logic [WORD_W-1:0] a1, c1, a2, c2;
  logic [WORD_W-1:0] x1, x2, x3, x4;
  logic [WORD_W-1:0] d1, b1, d2, b2;

  always_comb begin
    a1 = col_q.a + col_q.b;
    x1 = col_q.d ^ a1;
    d1 = {x1[15:0], x1[31:16]};
    c1 = col_q.c + d1;
    x2 = col_q.b ^ c1;
    b1 = {x2[19:0], x2[31:20]};
    a2 = a1 + b1;
    x3 = d1 ^ a2;
    d2 = {x3[23:0], x3[31:24]};
    c2 = c1 + d2;
    x4 = b1 ^ c2;
    b2 = {x4[24:0], x4[31:25]};
    qr_o = '{a: a2, b: b2, c: c2, d: d2};
  end

  always_comb begin
    col_d = col_q;
    if (load_i) begin
      col_d = init_i;
    end else if (step_i) begin
      col_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

// File: design/cc20_core.sv
// ChaCha20 block core: a ring of four column cells, one round per cycle,
// rows b/c/d handed between neighbours for the diagonal rounds; also the
// final feed-forward add and prefetch control. Depends on cc20_pkg, cc20_qr_cell.
`default_nettype none

module cc20_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cc20_pkg::cc20_cfg_t      cfg_i,
  input  cc20_pkg::cc20_core_ctl_t ctl_i,
  output logic                     hit_o,
  output cc20_pkg::cc20_block_t    ks_o
);
  import cc20_pkg::*;

  localparam logic [RND_W-1:0] RND_LAST = RND_W'(NUM_ROUNDS - 1);

  function automatic cc20_state_t init_state(cc20_cfg_t cfg, logic [WORD_W-1:0] ctr);
    cc20_state_t s;
    s = {cfg.nonce, ctr, cfg.key, SIGMA};
    return s;
  endfunction

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [RND_W-1:0]  rnd_q, rnd_d;
  logic [WORD_W-1:0] gen_ctr_q, gen_ctr_d;
  logic              load, step, match;
  cc20_state_t       init_ld, init_fin, work;

  cc20_col_t col  [CELLS];
  cc20_col_t qr   [CELLS];
  cc20_col_t nxt  [CELLS];
  cc20_col_t icol [CELLS];

  assign init_ld  = init_state(cfg_i, ctl_i.ctr);
  assign init_fin = init_state(cfg_i, gen_ctr_q);
  assign match    = (gen_ctr_q == ctl_i.ctr);
  assign hit_o    = done_q && match;

  // even round: columns; rotate rows so each cell holds a diagonal next.
  // odd round: diagonals; rotate back.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    localparam int Up1 = (k + 1) % CELLS;
    localparam int Up2 = (k + 2) % CELLS;
    localparam int Up3 = (k + 3) % CELLS;

    assign nxt[k] = rnd_q[0] ?
      cc20_col_t'{a: qr[k].a, b: qr[Up3].b, c: qr[Up2].c, d: qr[Up1].d} :
      cc20_col_t'{a: qr[k].a, b: qr[Up1].b, c: qr[Up2].c, d: qr[Up3].d};

    assign icol[k] = '{a: init_ld[k], b: init_ld[CELLS + k],
                       c: init_ld[2 * CELLS + k], d: init_ld[3 * CELLS + k]};

    cc20_qr_cell u_cell (
      .clk_i  (clk_i),
      .load_i (load),
      .step_i (step),
      .init_i (icol[k]),
      .nxt_i  (nxt[k]),
      .col_o  (col[k]),
      .qr_o   (qr[k])
    );
  end

  always_comb begin
    for (int c = 0; c < CELLS; c++) begin
      work[c]             = col[c].a;
      work[CELLS + c]     = col[c].b;
      work[2 * CELLS + c] = col[c].c;
      work[3 * CELLS + c] = col[c].d;
    end
    for (int j = 0; j < KS_WORDS; j++) begin
      ks_o[j] = {work[2 * j + 1] + init_fin[2 * j + 1], work[2 * j] + init_fin[2 * j]};
    end
  end

  always_comb begin
    run_d     = run_q;
    done_d    = done_q;
    rnd_d     = rnd_q;
    gen_ctr_d = gen_ctr_q;
    load      = 1'b0;
    step      = 1'b0;
    if (ctl_i.flush) begin
      run_d  = 1'b0;
      done_d = 1'b0;
    end else if (ctl_i.take) begin
      done_d = 1'b0;
    end else if ((run_q || done_q) && !match) begin
      // prefetched block is for a counter no longer wanted
      run_d  = 1'b0;
      done_d = 1'b0;
    end else if (!run_q && !done_q) begin
      load      = 1'b1;
      run_d     = 1'b1;
      rnd_d     = '0;
      gen_ctr_d = ctl_i.ctr;
    end else if (run_q) begin
      step  = 1'b1;
      rnd_d = rnd_q + RND_W'(1);
      if (rnd_q == RND_LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      done_q    <= 1'b0;
      rnd_q     <= '0;
      gen_ctr_q <= '0;
    end else begin
      run_q     <= run_d;
      done_q    <= done_d;
      rnd_q     <= rnd_d;
      gen_ctr_q <= gen_ctr_d;
    end
  end

  a_run_done_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(run_q && done_q))
    else $error("core running and done at once");

  a_flush_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.flush |=> !run_q && !done_q)
    else $error("flush did not drop the block");

  a_done_after_rounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(run_q) && ($past(rnd_q) == RND_LAST))
    else $error("block done before all rounds");

  a_rnd_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> rnd_q <= RND_LAST)
    else $error("round count out of range");

endmodule

`default_nettype wire

// File: design/chacha20_stream_xor.sv
// ChaCha20 stream XOR, eight bytes per word: config registers, keystream
// shift chain, message tracking and output skid. Depends on cc20_pkg, cc20_core.
//
// A result is registered when its word is accepted, into the skid register if the output stalls.
// Throughput: one word per cycle while the current 64-byte block lasts and the
// output is not stalled; each block is computed in the round core and is
// fetched ahead of need. A config write drops the fetched block, so the next
// word waits for a new block.
// Reset clears config registers, message position, core and output flags.
`default_nettype none

module chacha20_stream_xor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cc20_pkg::cc20_in_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cc20_pkg::cc20_out_t           out_word_o,
  input  logic                          cfg_wr_i,
  input  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cc20_pkg::DATA_W-1:0]   cfg_data_i
);
  import cc20_pkg::*;

  logic [NUM_CFG-1:0][DATA_W-1:0]  cfg_q, cfg_d;
  logic                            in_msg_q, in_msg_d;
  logic [POS_W-1:0]                pos_q, pos_d;
  logic [WORD_W-1:0]               blk_ctr_q, blk_ctr_d;
  logic [KS_WORDS-2:0][DATA_W-1:0] chain_q, chain_d;
  logic                            out_v_q, out_v_d;
  logic                            skid_v_q, skid_v_d;
  cc20_out_t                       out_q, out_d;
  cc20_out_t                       skid_q, skid_d;
  cc20_out_t                       res;
  cc20_cfg_t                       cfg;
  cc20_core_ctl_t                  ctl;
  cc20_block_t                     ks_blk;
  logic [WORD_W-1:0]               req_ctr;
  logic [DATA_W-1:0]               ks_word, mixed;
  logic                            need_blk, hit, in_acc, out_take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr_i) begin
      unique case (cfg_idx_i) inside
        CFG_KEY01, CFG_KEY23, CFG_KEY45, CFG_KEY67, CFG_IV01, CFG_IV23: begin
          cfg_d[cfg_idx_i] = cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  assign cfg.key   = {cfg_q[CFG_KEY67], cfg_q[CFG_KEY45], cfg_q[CFG_KEY23], cfg_q[CFG_KEY01]};
  assign cfg.nonce = {cfg_q[CFG_IV23], cfg_q[CFG_IV01][DATA_W-1:WORD_W]};

  // counter reloads from config at message start
  assign req_ctr  = in_msg_q ? blk_ctr_q : cfg_q[CFG_IV01][WORD_W-1:0];
  assign need_blk = (pos_q == '0);

  assign ctl.flush = cfg_wr_i;
  assign ctl.take  = in_acc && need_blk;
  assign ctl.ctr   = req_ctr;

  cc20_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .ctl_i  (ctl),
    .hit_o  (hit),
    .ks_o   (ks_blk)
  );

  assign in_stall_o = skid_v_q || (need_blk && !hit);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_v_q && !out_stall_i;

  assign ks_word = need_blk ? ks_blk[0] : chain_q[0];
  assign mixed   = in_word_i.data_in ^ ks_word;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      res.data_out[8 * b +: 8] = (in_word_i.byte_count > 4'(b)) ? mixed[8 * b +: 8] : 8'h00;
    end
    res.out_count = in_word_i.byte_count;
    res.out_last  = in_word_i.last;
  end

  // keystream chain: loaded from a new block, else cell i takes from cell i+1 on each word used
  always_comb begin
    chain_d   = chain_q;
    pos_d     = pos_q;
    in_msg_d  = in_msg_q;
    blk_ctr_d = blk_ctr_q;
    if (in_acc) begin
      if (need_blk) begin
        for (int i = 0; i < KS_WORDS - 1; i++) begin
          chain_d[i] = ks_blk[i + 1];
        end
        blk_ctr_d = req_ctr + 32'd1;
      end else begin
        for (int i = 0; i < KS_WORDS - 2; i++) begin
          chain_d[i] = chain_q[i + 1];
        end
      end
      in_msg_d = !in_word_i.last;
      pos_d    = in_word_i.last ? '0 : pos_q + POS_W'(1);
    end
  end

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (out_take) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_v_q || out_take) begin
        out_d   = res;
        out_v_d = 1'b1;
      end else begin
        skid_d   = res;
        skid_v_d = 1'b1;
      end
    end else if (out_take) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= '0;
      in_msg_q  <= 1'b0;
      pos_q     <= '0;
      blk_ctr_q <= '0;
      out_v_q   <= 1'b0;
      skid_v_q  <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      in_msg_q  <= in_msg_d;
      pos_q     <= pos_d;
      blk_ctr_q <= blk_ctr_d;
      out_v_q   <= out_v_d;
      skid_v_q  <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chain_q <= chain_d;
    out_q   <= out_d;
    skid_q  <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a word while output is empty");

  a_pos_in_msg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != '0) |-> in_msg_q)
    else $error("mid-block position outside a message");

  a_last_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.last |=> (pos_q == '0) && !in_msg_q)
    else $error("message end did not reset position");

  a_ctr_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && need_blk |=> blk_ctr_q == $past(req_ctr) + 32'd1)
    else $error("block counter did not advance");

endmodule

`default_nettype wire

// File: tb/chacha20_stream_xor_tb.sv
// Self-checking bench for chacha20_stream_xor: directed and random messages, with
// key, nonce and counter changes between phases and idling on both channels.
// Depends on cc20_pkg and the chacha20_stream_xor RTL.

// Keeps its own key, nonce, block counter and keystream block. It works out the
// expected output word for every accepted input word and checks the results in order.
class cc20_xor_predictor;
  logic [63:0]    key_pair [4];
  logic [63:0]    iv_low;
  logic [63:0]    iv_high;
  logic [63:0]    ks_block [8];
  bit   [2:0]     ks_pos;
  bit   [31:0]    blk_ctr;
  bit             mid_msg;
  bit   [31:0]    seed_w [16];
  bit   [31:0]    wk [16];
  cc20_pkg::cc20_out_t expected_words [$];
  int             errors;

  function new();
    foreach (key_pair[i]) key_pair[i] = '0;
    foreach (ks_block[i]) ks_block[i] = '0;
    iv_low  = '0;
    iv_high = '0;
    ks_pos  = '0;
    blk_ctr = '0;
    mid_msg = 1'b0;
    errors  = 0;
  endfunction

  function void set_reg(logic [cc20_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    case (idx)
      cc20_pkg::CFG_KEY01: key_pair[0] = val;
      cc20_pkg::CFG_KEY23: key_pair[1] = val;
      cc20_pkg::CFG_KEY45: key_pair[2] = val;
      cc20_pkg::CFG_KEY67: key_pair[3] = val;
      cc20_pkg::CFG_IV01:  iv_low      = val;
      cc20_pkg::CFG_IV23:  iv_high     = val;
      default: ;
    endcase
  endfunction

  function bit [31:0] rotl(bit [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function void qround(int a, int b, int c, int d);
    wk[a] += wk[b]; wk[d] = rotl(wk[d] ^ wk[a], 16);
    wk[c] += wk[d]; wk[b] = rotl(wk[b] ^ wk[c], 12);
    wk[a] += wk[b]; wk[d] = rotl(wk[d] ^ wk[a], 8);
    wk[c] += wk[d]; wk[b] = rotl(wk[b] ^ wk[c], 7);
  endfunction

  // one 64-byte keystream block from the current key, nonce and counter
  function void refill();
    for (int i = 0; i < 4; i++) begin
      seed_w[i]         = cc20_pkg::SIGMA[i];
      seed_w[4 + 2 * i] = key_pair[i][31:0];
      seed_w[5 + 2 * i] = key_pair[i][63:32];
    end
    seed_w[12] = blk_ctr;
    seed_w[13] = iv_low[63:32];
    seed_w[14] = iv_high[31:0];
    seed_w[15] = iv_high[63:32];
    wk = seed_w;
    for (int r = 0; r < cc20_pkg::DOUBLE_ROUNDS; r++) begin
      qround(0, 4, 8, 12);
      qround(1, 5, 9, 13);
      qround(2, 6, 10, 14);
      qround(3, 7, 11, 15);
      qround(0, 5, 10, 15);
      qround(1, 6, 11, 12);
      qround(2, 7, 8, 13);
      qround(3, 4, 9, 14);
    end
    for (int i = 0; i < 8; i++)
      ks_block[i] = {wk[2 * i + 1] + seed_w[2 * i + 1], wk[2 * i] + seed_w[2 * i]};
    blk_ctr++;
  endfunction

  function void take_word(cc20_pkg::cc20_in_t w);
    int unsigned         n;
    logic [63:0]         mask;
    cc20_pkg::cc20_out_t res;
    if (!mid_msg) begin
      blk_ctr = iv_low[31:0];
      ks_pos  = '0;
    end
    if (ks_pos == 0) refill();
    n    = (w.byte_count > 8) ? 8 : w.byte_count;
    mask = (n >= 8) ? '1 : (64'd1 << (8 * n)) - 64'd1;
    res.data_out  = (w.data_in ^ ks_block[ks_pos]) & mask;
    res.out_count = w.byte_count;
    res.out_last  = w.last;
    expected_words.push_back(res);
    // a short word not marked last still uses up a full keystream word
    if (w.last) begin
      mid_msg = 1'b0;
      ks_pos  = '0;
    end else begin
      mid_msg = 1'b1;
      ks_pos++;
    end
  endfunction

  task mismatch(string what);
    if (errors < 100) $display("mismatch: %s", what);
    errors++;
  endtask

  task check_word(cc20_pkg::cc20_out_t got);
    cc20_pkg::cc20_out_t want;
    if (expected_words.size() == 0) begin
      mismatch($sformatf("unexpected word %h", got));
      return;
    end
    want = expected_words.pop_front();
    if (got.data_out !== want.data_out)
      mismatch($sformatf("data_out %h, want %h", got.data_out, want.data_out));
    if (got.out_count !== want.out_count)
      mismatch($sformatf("out_count %0d, want %0d", got.out_count, want.out_count));
    if (got.out_last !== want.out_last)
      mismatch($sformatf("out_last %b, want %b", got.out_last, want.out_last));
  endtask
endclass

module chacha20_stream_xor_tb;
  import cc20_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int WORDS_PER_PHASE = 235;
  localparam int TAIL_CYCLES     = 40;
  localparam int CYCLE_LIMIT     = 400_000;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [NUM_CFG] = '{
    CFG_KEY01, CFG_KEY23, CFG_KEY45, CFG_KEY67, CFG_IV01, CFG_IV23
  };

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    val;
  } reg_write_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  cc20_in_t             in_word_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  cc20_out_t            out_word_o;
  logic                 cfg_wr_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [DATA_W-1:0]    cfg_data_i  = '0;

  cc20_xor_predictor sb = new();
  reg_write_t        reg_writes [$];
  bit                idle_on     = 1'b1;
  int                msg_left    = 0;
  int                stall_run   = 0;
  int                cycle_count = 0;

  chacha20_stream_xor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_wr_i    (cfg_wr_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: check accepted words, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(out_word_o);
    if (stall_run != 0) begin
      out_stall_i <= 1'b1;
      stall_run--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_run = $urandom_range(0, 4);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic cc20_in_t mk_word(logic [63:0] d, logic [3:0] n, logic l);
    cc20_in_t w;
    w.data_in    = d;
    w.byte_count = n;
    w.last       = l;
    return w;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_reg_value(logic [CFG_IDX_W-1:0] idx);
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      default: v = rnd64();
    endcase
    // start the counter just short of its wrap now and then
    if (idx == CFG_IV01 && $urandom_range(0, 3) == 0)
      v[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 3);
    return v;
  endfunction

  task automatic send_word(input cc20_in_t w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_word(w);
  endtask

  // hold off the sender until every expected word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_reg_writes();
    foreach (reg_writes[i]) begin
      cfg_wr_i   <= 1'b1;
      cfg_idx_i  <= reg_writes[i].idx;
      cfg_data_i <= reg_writes[i].val;
      @(posedge clk_i);
      sb.set_reg(reg_writes[i].idx, reg_writes[i].val);
    end
    cfg_wr_i <= 1'b0;
    reg_writes.delete();
  endtask

  task automatic send_random(input int n);
    cc20_in_t w;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2 && $urandom_range(0, 1) == 0) drain();
      if (msg_left == 0)
        msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                               : $urandom_range(1, 16);
      w.data_in = rnd64();
      if ($urandom_range(0, 7) == 0) begin
        // stray word: any count, any last flag
        w.byte_count = 4'($urandom_range(0, 15));
        w.last       = 1'($urandom_range(0, 1));
      end else begin
        w.last       = (msg_left == 1);
        w.byte_count = w.last ? 4'($urandom_range(1, 8)) : 4'd8;
      end
      if (w.last) msg_left = 0;
      else if (msg_left != 0) msg_left--;
      send_word(w);
    end
  endtask

  task automatic directed();
    // zero key and nonce from reset
    send_word(mk_word('0, 4'd8, 1'b1));
    send_word(mk_word('1, 4'd8, 1'b0));
    send_word(mk_word(rnd64(), 4'd0, 1'b0));
    send_word(mk_word(rnd64(), 4'd15, 1'b0));
    send_word(mk_word(rnd64(), 4'd3, 1'b0));
    repeat (4) send_word(mk_word(rnd64(), 4'd8, 1'b0));
    send_word(mk_word(rnd64(), 4'd9, 1'b0));
    send_word(mk_word(rnd64(), 4'd1, 1'b1));
    send_word(mk_word(rnd64(), 4'd0, 1'b1));
    // all-ones key and nonce, counter at its top so it wraps to zero
    drain();
    foreach (REG_ORDER[i]) reg_writes.push_back('{REG_ORDER[i], '1});
    apply_reg_writes();
    repeat (9) send_word(mk_word(rnd64(), 4'd8, 1'b0));
    send_word(mk_word(rnd64(), 4'd7, 1'b1));
    send_word(mk_word('1, 4'd8, 1'b1));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      foreach (REG_ORDER[i])
        if (phase == 0 || $urandom_range(0, 1) == 0)
          reg_writes.push_back('{REG_ORDER[i], pick_reg_value(REG_ORDER[i])});
      apply_reg_writes();
      if (phase == NUM_PHASES - 1) idle_on = 1'b0;
      send_random(WORDS_PER_PHASE);
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
